@@ hdl/tsgs_pkg.sv @@
// package for the two-species gillespie step block
// shared types, codes and widths; no dependencies
`default_nettype none
package tsgs_pkg;
  localparam int COUNT_W = 16;
  localparam int TIME_W = 48;
  localparam int COEF_W = 32;
  localparam int RATE_W = 64;
  localparam int NUM_REGS = 8;

  typedef logic [2:0] code_t;
  localparam code_t ST_STEPPED = 3'd0;
  localparam code_t ST_LOADED = 3'd1;
  localparam code_t ST_EXTINCT = 3'd2;
  localparam code_t ST_TIME = 3'd3;
  localparam code_t ST_ZERO = 3'd4;

  localparam code_t EV_FREE_BIRTH = 3'd0;
  localparam code_t EV_BEAR_BIRTH = 3'd1;
  localparam code_t EV_FREE_DEATH = 3'd2;
  localparam code_t EV_BEAR_DEATH = 3'd3;
  localparam code_t EV_LOSS = 3'd4;
  localparam code_t EV_CONJ = 3'd5;

  typedef struct packed {
    logic start;
  } mul_ctl_t;
endpackage
`default_nettype wire

@@ hdl/two_species_gillespie_step_top.sv @@
// top level of the two-species gillespie direct-method step block
// uses tsgs_pkg, tsgs_mul and tsgs_div
`default_nettype none
// A load request gives its result in the cycle after it is taken. A step
// request runs thirteen products through a bit-serial multiplier, then four
// passes that scale the uniform sample by the total while a bit-serial
// divider forms the time step in parallel, then an event search that checks
// one event per cycle. A time or extinction stop reports through S_OUT, and
// a zero total rate is found in S_DIV after the products and reports through
// S_OUT. One request is in work at a time and the input waits until the
// result is taken.
module two_species_gillespie_step_top #(
  parameter int DILUTION_STEP = 1
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [4:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic mode,
  input  wire logic [15:0] init_free,
  input  wire logic [15:0] init_bearing,
  input  wire logic [47:0] time_limit,
  input  wire logic [31:0] exp_sample,
  input  wire logic [31:0] uniform_sample,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [15:0] free_count,
  output logic [15:0] bearing_count,
  output logic [47:0] sim_time,
  output logic [2:0] event_kind,
  output logic [2:0] status
);
  import tsgs_pkg::*;
  localparam logic [16:0] DSTEP = 17'(DILUTION_STEP & 255);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_WAIT, S_TOTAL, S_DIV, S_UNI, S_UWAIT, S_PICK, S_OUT
  } state_t;

  logic [31:0] regs [NUM_REGS];
  logic [15:0] fpop, bpop;
  logic [47:0] ctime, etime;
  logic [31:0] expv, unif;
  state_t state;
  logic [3:0] op;
  logic [63:0] rate [6];
  logic [63:0] ta, tb;
  logic [63:0] total;
  logic [63:0] target;
  logic [2:0] pick;
  logic [63:0] run_sum;

  mul_ctl_t mctl;
  logic [63:0] ma;
  logic [15:0] mb;
  logic [63:0] mp;
  logic mdone;
  logic dstart, ddone;
  logic dfin;
  logic [55:0] dq;

  // uniform scaling: unif * total >> 32 via four 16-bit digits of total
  logic [1:0] upass;
  logic [95:0] uacc;
  logic [63:0] ua;
  logic [15:0] ub;
  logic [63:0] ucur;
  assign ucur = mp;
  assign ua = {32'd0, unif};
  assign ub = total[{upass, 4'b0000} +: 16];

  tsgs_mul u_mul (.clk, .rst, .ctl_in(mctl), .a(ma), .b(mb), .p(mp), .done(mdone));
  tsgs_div u_div (.clk, .rst, .start(dstart), .num({expv, 24'd0}), .den(total),
    .quo(dq), .done(ddone));

  assign pready = 1'b1;
  assign prdata = regs[paddr[4:2]];
  assign in_ready = (state == S_IDLE) && !out_valid;

  function automatic logic [63:0] sadd(input logic [63:0] x, input logic [63:0] y);
    logic [64:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [15:0] up(input logic [15:0] n);
    logic [16:0] s;
    s = {1'b0, n} + DSTEP;
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic logic [15:0] dn(input logic [15:0] n);
    return ({1'b0, n} > DSTEP) ? n - DSTEP[15:0] : 16'd0;
  endfunction

  // multiplier operand schedule
  always_comb begin
    ma = '0;
    mb = '0;
    if (state == S_UNI || state == S_UWAIT) begin
      ma = ua;
      mb = ub;
    end else begin
      case (op)
        4'd0: begin ma = {32'd0, regs[0]}; mb = fpop; end
        4'd1: begin ma = {32'd0, regs[1]}; mb = bpop; end
        4'd2: begin ma = {32'd0, regs[2]}; mb = fpop; end
        4'd3: begin ma = ta; mb = fpop; end
        4'd4: begin ma = {32'd0, regs[3]}; mb = fpop; end
        4'd5: begin ma = ta; mb = bpop; end
        4'd6: begin ma = {32'd0, regs[5]}; mb = bpop; end
        4'd7: begin ma = ta; mb = bpop; end
        4'd8: begin ma = {32'd0, regs[4]}; mb = bpop; end
        4'd9: begin ma = ta; mb = fpop; end
        4'd10: begin ma = {32'd0, regs[6]}; mb = bpop; end
        4'd11: begin ma = {32'd0, regs[7]}; mb = fpop; end
        4'd12: begin ma = ta; mb = bpop; end
        default: begin ma = '0; mb = '0; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) regs[i] <= '0;
    end else if (psel && penable && pwrite && (paddr[1:0] == 2'd0) && pready) begin
      regs[paddr[4:2]] <= pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      fpop <= '0;
      bpop <= '0;
      ctime <= '0;
      etime <= '0;
      mctl <= '0;
      dstart <= 1'b0;
      dfin <= 1'b0;
      op <= '0;
      upass <= '0;
    end else begin
      mctl.start <= 1'b0;
      dstart <= 1'b0;
      if (ddone) dfin <= 1'b1;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            expv <= exp_sample;
            unif <= uniform_sample;
            event_kind <= EV_FREE_BIRTH;
            if (!mode) begin
              fpop <= init_free;
              bpop <= init_bearing;
              etime <= time_limit;
              ctime <= '0;
              free_count <= init_free;
              bearing_count <= init_bearing;
              sim_time <= '0;
              status <= ST_LOADED;
              out_valid <= 1'b1;
            end else if (ctime >= etime) begin
              status <= ST_TIME;
              state <= S_OUT;
            end else if (fpop == 0 || bpop == 0) begin
              status <= ST_EXTINCT;
              state <= S_OUT;
            end else begin
              op <= 4'd0;
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          mctl.start <= 1'b1;
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (mdone) begin
            case (op)
              4'd0: rate[0] <= mp;
              4'd1: rate[1] <= mp;
              4'd3: tb <= mp;
              4'd5: rate[2] <= sadd(tb, mp);
              4'd7: tb <= mp;
              4'd9: rate[3] <= sadd(tb, mp);
              4'd10: rate[4] <= mp;
              4'd12: rate[5] <= mp;
              default: ta <= mp;
            endcase
            if (op == 4'd12) begin
              state <= S_TOTAL;
            end else begin
              op <= op + 4'd1;
              state <= S_MUL;
            end
          end
        end
        S_TOTAL: begin
          total <= sadd(sadd(sadd(rate[0], rate[1]), sadd(rate[2], rate[3])),
                        sadd(rate[4], rate[5]));
          state <= S_DIV;
          op <= 4'd15;
        end
        S_DIV: begin
          if (total == 0) begin
            status <= ST_ZERO;
            state <= S_OUT;
          end else if (op == 4'd15) begin
            dstart <= 1'b1;
            dfin <= 1'b0;
            op <= 4'd0;
            upass <= 2'd0;
            uacc <= '0;
            state <= S_UNI;
          end
        end
        S_UNI: begin
          mctl.start <= 1'b1;
          state <= S_UWAIT;
        end
        S_UWAIT: begin
          if (mdone) begin
            uacc <= uacc + ({32'd0, ucur} << (16 * upass));
            if (upass == 2'd3) begin
              state <= S_PICK;
              op <= 4'd0;
            end else begin
              upass <= upass + 2'd1;
              state <= S_UNI;
            end
          end
        end
        S_PICK: begin
          if (op == 4'd0) begin
            target <= uacc[95:32];
            run_sum <= '0;
            pick <= 3'd0;
            op <= 4'd1;
          end else if (op == 4'd1) begin
            if (pick == 3'd6) begin
              pick <= EV_CONJ;
              op <= 4'd2;
            end else if (target < sadd(run_sum, rate[pick])) begin
              op <= 4'd2;
            end else begin
              run_sum <= sadd(run_sum, rate[pick]);
              pick <= pick + 3'd1;
            end
          end else if (dfin) begin
            begin
              logic [48:0] nt;
              nt = {1'b0, ctime} + {1'b0, dq[47:0]};
              ctime <= (nt[48] || dq[55:48] != 0) ? '1 : nt[47:0];
            end
            case (pick)
              EV_FREE_BIRTH: fpop <= up(fpop);
              EV_BEAR_BIRTH: bpop <= up(bpop);
              EV_FREE_DEATH: fpop <= dn(fpop);
              EV_BEAR_DEATH: bpop <= dn(bpop);
              EV_LOSS: begin bpop <= dn(bpop); fpop <= up(fpop); end
              default: begin bpop <= up(bpop); fpop <= dn(fpop); end
            endcase
            event_kind <= (pick > EV_CONJ) ? EV_CONJ : pick;
            status <= ST_STEPPED;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          free_count <= fpop;
          bearing_count <= bpop;
          sim_time <= ctime;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  chk_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  chk_load: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !mode) |=> out_valid && status == ST_LOADED)
    else $error("load did not report");
  chk_kind: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_STEPPED) |-> event_kind == EV_FREE_BIRTH)
    else $error("event kind set on non-step result");
endmodule
`default_nettype wire

@@ hdl/tsgs_mul.sv @@
// bit-serial multiplier: 64-bit multiplicand times 16-bit multiplier
// one multiplier bit per cycle, product saturates at 64 bits; uses tsgs_pkg
`default_nettype none
module tsgs_mul (
  input  wire logic clk,
  input  wire logic rst,
  input  tsgs_pkg::mul_ctl_t ctl_in,
  input  wire logic [63:0] a,
  input  wire logic [15:0] b,
  output logic [63:0] p,
  output logic done
);
  import tsgs_pkg::*;
  logic [63:0] acc;
  logic [63:0] mcand;
  logic [15:0] mplier;
  logic [4:0] cnt;
  logic run;
  logic sat;
  logic [64:0] sum;

  assign sum = {1'b0, acc} + {1'b0, mcand};
  assign p = sat ? '1 : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (ctl_in.start) begin
        run <= 1'b1;
        cnt <= 5'd16;
        acc <= '0;
        sat <= 1'b0;
        mcand <= a;
        mplier <= b;
      end else if (run) begin
        if (mplier[0]) begin
          if (sum[64]) sat <= 1'b1;
          acc <= sum[63:0];
        end
        if (mcand[63] && (mplier[15:1] != '0)) sat <= 1'b1;
        mcand <= {mcand[62:0], 1'b0};
        mplier <= {1'b0, mplier[15:1]};
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  chk_done: assert property (@(posedge clk) disable iff (rst) done |-> !run)
    else $error("multiplier done while running");
  chk_start: assert property (@(posedge clk) disable iff (rst)
    ctl_in.start |=> run) else $error("multiplier did not start");
  chk_cnt: assert property (@(posedge clk) disable iff (rst)
    run |-> cnt != 5'd0) else $error("multiplier count out of range");
endmodule
`default_nettype wire

@@ hdl/tsgs_div.sv @@
// restoring bit-serial divider, 56-bit dividend by 64-bit divisor
// one quotient bit per cycle; no dependencies
`default_nettype none
module tsgs_div (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic [55:0] num,
  input  wire logic [63:0] den,
  output logic [55:0] quo,
  output logic done
);
  logic [64:0] rem;
  logic [63:0] dv;
  logic [5:0] cnt;
  logic run;
  logic [64:0] trial;
  logic [64:0] shifted;

  assign shifted = {rem[63:0], quo[55]};
  assign trial = shifted - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 6'd56;
        rem <= '0;
        quo <= num;
        dv <= den;
      end else if (run) begin
        if (!trial[64]) begin
          rem <= trial;
          quo <= {quo[54:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[54:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  chk_done: assert property (@(posedge clk) disable iff (rst) done |-> !run)
    else $error("divider done while running");
  chk_rem: assert property (@(posedge clk) disable iff (rst)
    run |-> rem <= {1'b0, dv}) else $error("divider remainder too large");
  chk_start: assert property (@(posedge clk) disable iff (rst)
    start |=> run) else $error("divider did not start");
endmodule
`default_nettype wire
